>>> rtl/core/bcgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgt_pkg
// Shared types and constants of the cubic Bezier gait trajectory block.
// ----------------------------------------------------------------------------
package bcgt_pkg;

  // width of the configuration register index
  localparam int CFG_IDX_BITS = 3;

  // configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CTRL0_X = 3'd0,
    REG_CTRL0_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_CTRL3_X = 3'd6,
    REG_CTRL3_Y = 3'd7
  } bcgt_reg_t;

  // reset values of the control points, q8.8
  localparam int RST_CTRL0_X = -1024;
  localparam int RST_CTRL0_Y = -3840;
  localparam int RST_CTRL1_X = -1024;
  localparam int RST_CTRL1_Y = -3328;
  localparam int RST_CTRL2_X = 768;
  localparam int RST_CTRL2_Y = -3328;
  localparam int RST_CTRL3_X = 768;
  localparam int RST_CTRL3_Y = -3840;

  // control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic stance;
  } bcgt_ctl_t;

endpackage

>>> rtl/core/bcgt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgt_cfg
// Control point register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bcgt_cfg #(
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bcgt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_wdata,
  output logic [3:0][COORD_BITS-1:0]             ctrl_x,
  output logic [3:0][COORD_BITS-1:0]             ctrl_y
);

  logic [3:0][COORD_BITS-1:0] ctrl_x_r;
  logic [3:0][COORD_BITS-1:0] ctrl_y_r;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_x_r[0] <= COORD_BITS'(bcgt_pkg::RST_CTRL0_X);
      ctrl_y_r[0] <= COORD_BITS'(bcgt_pkg::RST_CTRL0_Y);
      ctrl_x_r[1] <= COORD_BITS'(bcgt_pkg::RST_CTRL1_X);
      ctrl_y_r[1] <= COORD_BITS'(bcgt_pkg::RST_CTRL1_Y);
      ctrl_x_r[2] <= COORD_BITS'(bcgt_pkg::RST_CTRL2_X);
      ctrl_y_r[2] <= COORD_BITS'(bcgt_pkg::RST_CTRL2_Y);
      ctrl_x_r[3] <= COORD_BITS'(bcgt_pkg::RST_CTRL3_X);
      ctrl_y_r[3] <= COORD_BITS'(bcgt_pkg::RST_CTRL3_Y);
    end else if (cfg_valid) begin
      unique case (bcgt_pkg::bcgt_reg_t'(cfg_index))
        bcgt_pkg::REG_CTRL0_X: ctrl_x_r[0] <= cfg_wdata;
        bcgt_pkg::REG_CTRL0_Y: ctrl_y_r[0] <= cfg_wdata;
        bcgt_pkg::REG_CTRL1_X: ctrl_x_r[1] <= cfg_wdata;
        bcgt_pkg::REG_CTRL1_Y: ctrl_y_r[1] <= cfg_wdata;
        bcgt_pkg::REG_CTRL2_X: ctrl_x_r[2] <= cfg_wdata;
        bcgt_pkg::REG_CTRL2_Y: ctrl_y_r[2] <= cfg_wdata;
        bcgt_pkg::REG_CTRL3_X: ctrl_x_r[3] <= cfg_wdata;
        bcgt_pkg::REG_CTRL3_Y: ctrl_y_r[3] <= cfg_wdata;
        default:               ctrl_x_r[0] <= ctrl_x_r[0];
      endcase
    end
  end

  assign ctrl_x = ctrl_x_r;
  assign ctrl_y = ctrl_y_r;

endmodule

>>> rtl/core/bcgt_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgt_weights
// Two pipeline stages forming the Bernstein weights of t = 2*phase modulo 1.
// ----------------------------------------------------------------------------
module bcgt_weights #(
  parameter int PHASE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  bcgt_pkg::bcgt_ctl_t   in_ctl,
  input  logic [PHASE_BITS-1:0] phase,
  output bcgt_pkg::bcgt_ctl_t   w_ctl,
  output logic [PHASE_BITS:0]   w0,
  output logic [PHASE_BITS+1:0] w1,
  output logic [PHASE_BITS+1:0] w2,
  output logic [PHASE_BITS-1:0] w3
);

  localparam int P = PHASE_BITS;

  // stage 1: t, u = 1 - t, squares
  logic [P-1:0]     t;
  logic [P:0]       u;
  logic [2*P+1:0]   uu;
  logic [2*P-1:0]   tt;
  bcgt_pkg::bcgt_ctl_t s1_ctl_r, s1_ctl_nxt;
  logic [P-1:0]     t_r;
  logic [P:0]       u_r;
  logic [P:0]       u2_r;
  logic [P-1:0]     t2_r;

  always_comb begin
    t   = {phase[P-2:0], 1'b0};
    u   = {1'b1, {P{1'b0}}} - {1'b0, t};
    uu  = (2*P+2)'(u) * (2*P+2)'(u);
    tt  = (2*P)'(t) * (2*P)'(t);
    s1_ctl_nxt.valid  = in_ctl.valid;
    s1_ctl_nxt.stance = phase[P-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r             <= t;
      u_r             <= u;
      u2_r            <= uu[2*P:P];
      t2_r            <= tt[2*P-1:P];
    end
  end

  // stage 2: cubes and mixed terms, each truncated
  logic [2*P+1:0] uuu;
  logic [2*P:0]   uut;
  logic [2*P:0]   utt;
  logic [2*P-1:0] ttt;
  logic [P+1:0]   w1_nxt, w2_nxt;
  bcgt_pkg::bcgt_ctl_t s2_ctl_r;
  logic [P:0]     w0_r;
  logic [P+1:0]   w1_r, w2_r;
  logic [P-1:0]   w3_r;

  always_comb begin
    uuu    = (2*P+2)'(u2_r) * (2*P+2)'(u_r);
    uut    = (2*P+1)'(u2_r) * (2*P+1)'(t_r);
    utt    = (2*P+1)'(u_r) * (2*P+1)'(t2_r);
    ttt    = (2*P)'(t2_r) * (2*P)'(t_r);
    // times three as x + 2x
    w1_nxt = {2'b00, uut[2*P-1:P]} + {1'b0, uut[2*P-1:P], 1'b0};
    w2_nxt = {2'b00, utt[2*P-1:P]} + {1'b0, utt[2*P-1:P], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w0_r            <= uuu[2*P:P];
      w1_r            <= w1_nxt;
      w2_r            <= w2_nxt;
      w3_r            <= ttt[2*P-1:P];
    end
  end

  assign w_ctl = s2_ctl_r;
  assign w0    = w0_r;
  assign w1    = w1_r;
  assign w2    = w2_r;
  assign w3    = w3_r;

endmodule

>>> rtl/core/bcgt_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcgt_blend
// Weights times control points, a two level adder tree and the output stage.
// ----------------------------------------------------------------------------
module bcgt_blend #(
  parameter int PHASE_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  bcgt_pkg::bcgt_ctl_t               w_ctl,
  input  logic [PHASE_BITS:0]               w0,
  input  logic [PHASE_BITS+1:0]             w1,
  input  logic [PHASE_BITS+1:0]             w2,
  input  logic [PHASE_BITS-1:0]             w3,
  input  logic [3:0][COORD_BITS-1:0]        ctrl_x,
  input  logic [3:0][COORD_BITS-1:0]        ctrl_y,
  output logic                              out_valid,
  output logic [COORD_BITS-1:0]             out_foot_x,
  output logic [COORD_BITS-1:0]             out_foot_y
);

  localparam int P   = PHASE_BITS;
  localparam int C   = COORD_BITS;
  localparam int PW  = P + C + 3;
  localparam int SW  = PW + 1;
  localparam int AW  = PW + 2;

  // stage 3: eight products, x points reversed in stance
  logic signed [P+2:0]   ws [4];
  logic signed [C-1:0]   ax [4];
  logic signed [C-1:0]   ay [4];
  logic signed [PW-1:0]  px_nxt [4];
  logic signed [PW-1:0]  py_nxt [4];
  logic signed [PW-1:0]  px_r [4];
  logic signed [PW-1:0]  py_r [4];
  bcgt_pkg::bcgt_ctl_t   s3_ctl_r;

  always_comb begin
    ws[0] = $signed({2'b00, w0});
    ws[1] = $signed({1'b0, w1});
    ws[2] = $signed({1'b0, w2});
    ws[3] = $signed({3'b000, w3});
    for (int k = 0; k < 4; k++) begin
      ax[k]     = w_ctl.stance ? $signed(ctrl_x[3-k]) : $signed(ctrl_x[k]);
      ay[k]     = $signed(ctrl_y[k]);
      px_nxt[k] = PW'(ws[k]) * PW'(ax[k]);
      py_nxt[k] = PW'(ws[k]) * PW'(ay[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= w_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        px_r[k] <= px_nxt[k];
        py_r[k] <= py_nxt[k];
      end
    end
  end

  // stage 4: pairwise sums
  logic signed [SW-1:0] sx_r [2];
  logic signed [SW-1:0] sy_r [2];
  bcgt_pkg::bcgt_ctl_t  s4_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (adv) begin
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r[0] <= SW'(px_r[0]) + SW'(px_r[1]);
      sx_r[1] <= SW'(px_r[2]) + SW'(px_r[3]);
      sy_r[0] <= SW'(py_r[0]) + SW'(py_r[1]);
      sy_r[1] <= SW'(py_r[2]) + SW'(py_r[3]);
    end
  end

  // stage 5: final sum, floor shift by the phase fraction, stance height
  logic signed [AW-1:0] accx, accy;
  logic [C-1:0]         foot_x_nxt, foot_y_nxt;
  logic                 out_valid_r;
  logic [C-1:0]         foot_x_r, foot_y_r;

  always_comb begin
    accx       = AW'(sx_r[0]) + AW'(sx_r[1]);
    accy       = AW'(sy_r[0]) + AW'(sy_r[1]);
    foot_x_nxt = accx[P+C-1:P];
    foot_y_nxt = s4_ctl_r.stance ? ctrl_y[0] : accy[P+C-1:P];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      foot_x_r <= foot_x_nxt;
      foot_y_r <= foot_y_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_foot_x = foot_x_r;
  assign out_foot_y = foot_y_r;

endmodule

>>> rtl/core/cubic_bezier_gait_trajectory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_gait_trajectory
// Foot position on a cubic Bezier swing curve and a reversed stance sweep.
//
//   channel   handshake            payload
//   in_       in_valid / in_stall  in_phase     (u0.PHASE_BITS)
//   out_      out_valid/ out_stall out_foot_x, out_foot_y (signed q8.8)
//   cfg_      cfg_valid/ cfg_ready cfg_index, cfg_wdata   (control points)
//
// one request per cycle while no result is held at the output; a result is
// valid once its request has passed the five register stages, which are
// the two weight stages, the product stage, the adder tree and the output
// register.
// synchronous active-low reset clears all valid bits and loads the
// default control points.
// a held result freezes the whole pipeline and stalls the input side.
// ----------------------------------------------------------------------------
module cubic_bezier_gait_trajectory #(
  parameter int PHASE_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PHASE_BITS-1:0]             in_phase,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [COORD_BITS-1:0]             out_foot_x,
  output logic [COORD_BITS-1:0]             out_foot_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bcgt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_wdata
);

  logic [3:0][COORD_BITS-1:0] ctrl_x;
  logic [3:0][COORD_BITS-1:0] ctrl_y;
  logic                       adv;
  bcgt_pkg::bcgt_ctl_t        in_ctl;
  bcgt_pkg::bcgt_ctl_t        w_ctl;
  logic [PHASE_BITS:0]        w0;
  logic [PHASE_BITS+1:0]      w1;
  logic [PHASE_BITS+1:0]      w2;
  logic [PHASE_BITS-1:0]      w3;

  // pipeline moves unless a result is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign in_ctl.valid  = in_valid;
  assign in_ctl.stance = in_phase[PHASE_BITS-1];

  // control point registers
  bcgt_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctrl_x    (ctrl_x),
    .ctrl_y    (ctrl_y)
  );

  // bernstein weights
  bcgt_weights #(
    .PHASE_BITS (PHASE_BITS)
  ) u_weights (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_ctl (in_ctl),
    .phase  (in_phase),
    .w_ctl  (w_ctl),
    .w0     (w0),
    .w1     (w1),
    .w2     (w2),
    .w3     (w3)
  );

  // weighted sum of control points and output register
  bcgt_blend #(
    .PHASE_BITS (PHASE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .w_ctl      (w_ctl),
    .w0         (w0),
    .w1         (w1),
    .w2         (w2),
    .w3         (w3),
    .ctrl_x     (ctrl_x),
    .ctrl_y     (ctrl_y),
    .out_valid  (out_valid),
    .out_foot_x (out_foot_x),
    .out_foot_y (out_foot_y)
  );

endmodule
